/* hdl/rffv_pkg.sv */
// ----------------------------------------------------------------------------
// Radial force field package
// Shared widths, register codes, payload structs and the exp2 constant table.
// ----------------------------------------------------------------------------
package rffv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LOG_BITS  = 16;
	localparam int MANT_BITS = 16;
	localparam int POS_W     = 32;
	localparam int DT_W      = 17;
	localparam int IDX_W     = 16;
	localparam int STR_W     = 23;
	localparam int FALL_W    = 19;
	localparam int RANGE_W   = 23;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Smallest distance that still gets a force: 1e-4 in raw units, at least one.
	localparam int MIN_DIST_CALC = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int MIN_DIST_RAW  = (MIN_DIST_CALC > 0) ? MIN_DIST_CALC : 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_STRENGTH = 3'd3,
		REG_FALLOFF  = 3'd4,
		REG_RANGE    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic signed [POS_W-1:0] vel_z;
		logic [DT_W-1:0]         time_step;
		logic [IDX_W-1:0]        particle_index;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_vel_x;
		logic signed [POS_W-1:0] new_vel_y;
		logic signed [POS_W-1:0] new_vel_z;
		logic                    applied;
		logic [IDX_W-1:0]        index_out;
	} rsp_t;

	typedef struct packed {
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
		logic signed [POS_W-1:0] center_z;
		logic signed [STR_W-1:0] field_strength;
		logic [FALL_W-1:0]       falloff_exponent;
		logic [RANGE_W-1:0]      max_range;
	} cfg_t;

	typedef logic [30:0] expc_tab_t [LOG_BITS];

	// Integer square root, used only to build the constant table.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'd1 << 62;
		x = v;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Entry j is 2^(2^-(j+1)) in Q1.30, each one the root of the one before.
	function automatic expc_tab_t build_exp_tab();
		expc_tab_t  t;
		logic [63:0] c;
		c = isqrt64(64'd2 << 60);
		for (int j = 0; j < LOG_BITS; j++) begin
			t[j] = c[30:0];
			c = isqrt64(c << 30);
		end
		return t;
	endfunction

	localparam expc_tab_t EXP_C = build_exp_tab();

endpackage

/* hdl/radial_force_field_velocity_update_top.sv */
// ----------------------------------------------------------------------------
// Radial force field velocity update
// Fifty-stage pipeline adding an inverse-power radial force to particle speed.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// request   in         start, busy            req (rffv_pkg::req_t)
// result    out        done (one-cycle pulse)  result (rffv_pkg::rsp_t)
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A request is taken at every clock edge where start is high; busy stays low,
// so one particle enters per cycle. Results come out of the last of the
// NUM_STG (50) stages in request order. The depth is set by the serial chain
// of the square root (eight stages of three bits), the 16 log2 squaring stages
// and the 16 exp2 multiply stages. Reset clears only the stage valid bits and
// the register bank. The receiver cannot hold results off, so the pipeline
// never stalls; done is high for exactly the one cycle a result is present.
//
module radial_force_field_velocity_update_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  rffv_pkg::req_t                 req,
	output logic                           done,
	output rffv_pkg::rsp_t                 result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rffv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rffv_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rffv_pkg::*;

	// Stage map. The divider runs alongside the first log2 stages.
	localparam int SQ_STG   = 8;
	localparam int DIV_STG  = 10;
	localparam int LOG_STG  = LOG_BITS;
	localparam int EXP_STG  = LOG_BITS;
	localparam int ST_MUL   = 1;
	localparam int ST_SUM   = 2;
	localparam int ST_SQ0   = 3;
	localparam int ST_NORM  = ST_SQ0 + SQ_STG;
	localparam int ST_LOG0  = ST_NORM + 1;
	localparam int ST_FMUL  = ST_LOG0 + LOG_STG;
	localparam int ST_EXPS  = ST_FMUL + 1;
	localparam int ST_EXP0  = ST_EXPS + 1;
	localparam int ST_RMUL  = ST_EXP0 + EXP_STG;
	localparam int ST_RSUM  = ST_RMUL + 1;
	localparam int ST_SHIFT = ST_RSUM + 1;
	localparam int ST_ADD   = ST_SHIFT + 1;
	localparam int NUM_STG  = ST_ADD + 1;

	localparam logic signed [21:0] LG_BIAS = 22'(FRAC_BITS << LOG_BITS);
	localparam logic signed [10:0] SH_BIAS = 11'(FRAC_BITS + MANT_BITS);
	localparam logic [56:0]        MAG_CAP = 57'd1 << 34;

	// Everything one particle needs on its way down the pipeline.
	typedef struct packed {
		logic [2:0][31:0]   vel;
		logic [IDX_W-1:0]   idx;
		logic [2:0]         dneg;
		logic               sneg;
		logic               ok;
		logic [2:0][22:0]   a;
		logic [39:0]        p;
		logic [2:0][45:0]   sq;
		logic [2:0][42:0]   pal;
		logic [2:0][42:0]   pah;
		logic [47:0]        sv;
		logic [26:0]        srem;
		logic [23:0]        root;
		logic [2:0][23:0]   drem;
		logic [2:0][39:0]   dnum;
		logic [30:0]        lm;
		logic [20:0]        lres;
		logic signed [40:0] fprod;
		logic signed [9:0]  ei;
		logic [LOG_BITS-1:0] ef;
		logic [30:0]        em;
		logic [2:0][36:0]   rl;
		logic [2:0][36:0]   rh;
		logic [2:0][56:0]   r;
		logic [2:0][56:0]   mag;
		logic [2:0][31:0]   nvel;
	} pipe_t;

	cfg_t  regs;
	pipe_t pipe_s [NUM_STG];
	logic  vld_s  [NUM_STG];
	pipe_t nxt_in;

	rffv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Offset to the center, component range check and |strength| * dt.
	function automatic pipe_t f_in(input req_t q, input cfg_t c);
		pipe_t o;
		logic signed [32:0] d;
		logic [32:0] ad;
		logic [31:0] cc [3];
		logic [31:0] pp [3];
		logic [STR_W-1:0] smag;
		logic inr;
		o = '0;
		cc[0] = c.center_x;
		cc[1] = c.center_y;
		cc[2] = c.center_z;
		pp[0] = q.pos_x;
		pp[1] = q.pos_y;
		pp[2] = q.pos_z;
		o.vel[0] = q.vel_x;
		o.vel[1] = q.vel_y;
		o.vel[2] = q.vel_z;
		o.idx = q.particle_index;
		inr = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d = $signed({cc[i][31], cc[i]}) - $signed({pp[i][31], pp[i]});
			ad = d[32] ? 33'(-d) : 33'(d);
			o.dneg[i] = d[32];
			o.a[i] = ad[22:0];
			inr = inr && (ad <= {10'b0, c.max_range});
		end
		o.ok = inr;
		o.sneg = c.field_strength[STR_W-1];
		smag = o.sneg ? STR_W'(-c.field_strength) : STR_W'(c.field_strength);
		o.p = {17'b0, smag} * {23'b0, q.time_step};
		return o;
	endfunction

	function automatic pipe_t f_mul(input pipe_t x);
		pipe_t o;
		o = x;
		for (int i = 0; i < 3; i++) begin
			o.sq[i]  = {23'b0, x.a[i]} * {23'b0, x.a[i]};
			o.pal[i] = {3'b0, x.p[19:0]} * {20'b0, x.a[i]};
			o.pah[i] = {3'b0, x.p[39:20]} * {20'b0, x.a[i]};
		end
		return o;
	endfunction

	function automatic pipe_t f_sum(input pipe_t x);
		pipe_t o;
		logic [62:0] n;
		o = x;
		o.sv = 48'(x.sq[0]) + 48'(x.sq[1]) + 48'(x.sq[2]);
		for (int i = 0; i < 3; i++) begin
			n = (63'(x.pah[i]) << 20) + 63'(x.pal[i]);
			o.drem[i] = {1'b0, n[62:40]};
			o.dnum[i] = n[39:0];
		end
		o.srem = '0;
		o.root = '0;
		return o;
	endfunction

	// Three digits of the square root, two radicand bits each.
	function automatic pipe_t f_sqrt(input pipe_t x);
		pipe_t o;
		logic [26:0] rem2;
		logic [26:0] trial;
		o = x;
		for (int s = 0; s < 3; s++) begin
			rem2  = {o.srem[24:0], o.sv[47:46]};
			trial = {1'b0, o.root, 2'b01};
			if (rem2 >= trial) begin
				o.srem = rem2 - trial;
				o.root = {o.root[22:0], 1'b1};
			end else begin
				o.srem = rem2;
				o.root = {o.root[22:0], 1'b0};
			end
			o.sv = {o.sv[45:0], 2'b00};
		end
		return o;
	endfunction

	// Distance checks, then the integer part of log2 and a normalized mantissa.
	function automatic pipe_t f_norm(input pipe_t x, input cfg_t c);
		pipe_t o;
		logic [4:0] n;
		logic [54:0] tmp;
		o = x;
		o.ok = x.ok && (x.root >= 24'(MIN_DIST_RAW)) && (x.root <= {1'b0, c.max_range});
		n = '0;
		for (int b = 0; b < 24; b++) begin
			if (x.root[b]) begin
				n = 5'(b);
			end
		end
		tmp = 55'(x.root) << (5'd30 - n);
		o.lm = tmp[30:0];
		o.lres = 21'(n);
		return o;
	endfunction

	// One log2 fraction bit by squaring; optionally four quotient bits per axis.
	function automatic pipe_t f_logdiv(input pipe_t x, input logic dodiv);
		pipe_t o;
		logic [61:0] sqm;
		logic [24:0] r2;
		logic qb;
		o = x;
		sqm = {31'b0, x.lm} * {31'b0, x.lm};
		if (sqm[61]) begin
			o.lm = sqm[61:31];
			o.lres = {x.lres[19:0], 1'b1};
		end else begin
			o.lm = sqm[60:30];
			o.lres = {x.lres[19:0], 1'b0};
		end
		if (dodiv) begin
			for (int i = 0; i < 3; i++) begin
				for (int s = 0; s < 4; s++) begin
					r2 = {o.drem[i], o.dnum[i][39]};
					qb = (r2 >= {1'b0, x.root});
					if (qb) begin
						r2 = r2 - {1'b0, x.root};
					end
					o.drem[i] = r2[23:0];
					o.dnum[i] = {o.dnum[i][38:0], qb};
				end
			end
		end
		return o;
	endfunction

	function automatic pipe_t f_fmul(input pipe_t x, input cfg_t c);
		pipe_t o;
		logic signed [21:0] lg;
		logic signed [40:0] fa;
		logic signed [40:0] fl;
		o = x;
		lg = $signed({1'b0, x.lres}) - LG_BIAS;
		fa = $signed({22'b0, c.falloff_exponent});
		fl = 41'(lg);
		o.fprod = fa * fl;
		return o;
	endfunction

	function automatic pipe_t f_exps(input pipe_t x);
		pipe_t o;
		logic signed [40:0] e;
		logic signed [40:0] eint;
		o = x;
		e = -(x.fprod >>> FRAC_BITS);
		eint = e >>> LOG_BITS;
		o.ei = 10'(eint);
		o.ef = e[LOG_BITS-1:0];
		o.em = 31'd1 << 30;
		return o;
	endfunction

	function automatic pipe_t f_exp(input pipe_t x, input int j);
		pipe_t o;
		logic [61:0] pm;
		o = x;
		pm = {31'b0, x.em} * {31'b0, EXP_C[j]};
		if (x.ef[LOG_BITS-1-j]) begin
			o.em = pm[60:30];
		end
		return o;
	endfunction

	function automatic pipe_t f_rmul(input pipe_t x);
		pipe_t o;
		logic [16:0] m16;
		o = x;
		m16 = x.em[30:14];
		for (int i = 0; i < 3; i++) begin
			o.rl[i] = {17'b0, x.dnum[i][19:0]} * {20'b0, m16};
			o.rh[i] = {17'b0, x.dnum[i][39:20]} * {20'b0, m16};
		end
		return o;
	endfunction

	function automatic pipe_t f_rsum(input pipe_t x);
		pipe_t o;
		o = x;
		for (int i = 0; i < 3; i++) begin
			o.r[i] = (57'(x.rh[i]) << 20) + 57'(x.rl[i]);
		end
		return o;
	endfunction

	// Scale by 2^(ei - 32): left shifts cap at 2^34, right shifts truncate.
	function automatic pipe_t f_shift(input pipe_t x);
		pipe_t o;
		logic signed [10:0] sh;
		logic [10:0] nsh;
		logic [96:0] wide;
		o = x;
		sh = 11'(x.ei) - SH_BIAS;
		nsh = 11'(-sh);
		for (int i = 0; i < 3; i++) begin
			wide = 97'(x.r[i]) << sh[5:0];
			if (x.r[i] == '0) begin
				o.mag[i] = '0;
			end else if (!sh[10]) begin
				if (sh >= 11'sd40 || wide > 97'(MAG_CAP)) begin
					o.mag[i] = MAG_CAP;
				end else begin
					o.mag[i] = wide[56:0];
				end
			end else if (nsh >= 11'd64) begin
				o.mag[i] = '0;
			end else begin
				o.mag[i] = x.r[i] >> nsh[5:0];
			end
		end
		return o;
	endfunction

	function automatic pipe_t f_add(input pipe_t x);
		pipe_t o;
		logic signed [58:0] v;
		logic signed [58:0] mg;
		logic signed [58:0] s;
		o = x;
		for (int i = 0; i < 3; i++) begin
			v  = 59'($signed(x.vel[i]));
			mg = $signed({2'b0, x.mag[i]});
			s  = (x.sneg ^ x.dneg[i]) ? v - mg : v + mg;
			if (!x.ok) begin
				o.nvel[i] = x.vel[i];
			end else if (s > 59'sd2147483647) begin
				o.nvel[i] = 32'h7fff_ffff;
			end else if (s < -59'sd2147483648) begin
				o.nvel[i] = 32'h8000_0000;
			end else begin
				o.nvel[i] = s[31:0];
			end
		end
		return o;
	endfunction

	// A request is taken in every cycle.
	assign busy   = 1'b0;
	assign nxt_in = f_in(req, regs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= nxt_in;
	end

	for (genvar k = 1; k < NUM_STG; k++) begin : g_stage
		pipe_t nxt;
		if (k == ST_MUL) begin : g_mul
			assign nxt = f_mul(pipe_s[k-1]);
		end else if (k == ST_SUM) begin : g_sum
			assign nxt = f_sum(pipe_s[k-1]);
		end else if (k >= ST_SQ0 && k < ST_NORM) begin : g_sqrt
			assign nxt = f_sqrt(pipe_s[k-1]);
		end else if (k == ST_NORM) begin : g_norm
			assign nxt = f_norm(pipe_s[k-1], regs);
		end else if (k >= ST_LOG0 && k < ST_FMUL) begin : g_log
			assign nxt = f_logdiv(pipe_s[k-1], 1'(k < ST_LOG0 + DIV_STG));
		end else if (k == ST_FMUL) begin : g_fmul
			assign nxt = f_fmul(pipe_s[k-1], regs);
		end else if (k == ST_EXPS) begin : g_exps
			assign nxt = f_exps(pipe_s[k-1]);
		end else if (k >= ST_EXP0 && k < ST_RMUL) begin : g_exp
			assign nxt = f_exp(pipe_s[k-1], k - ST_EXP0);
		end else if (k == ST_RMUL) begin : g_rmul
			assign nxt = f_rmul(pipe_s[k-1]);
		end else if (k == ST_RSUM) begin : g_rsum
			assign nxt = f_rsum(pipe_s[k-1]);
		end else if (k == ST_SHIFT) begin : g_shift
			assign nxt = f_shift(pipe_s[k-1]);
		end else begin : g_add
			assign nxt = f_add(pipe_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			pipe_s[k] <= nxt;
		end
	end

	// The last stage is the output register.
	assign done             = vld_s[ST_ADD];
	assign result.new_vel_x = pipe_s[ST_ADD].nvel[0];
	assign result.new_vel_y = pipe_s[ST_ADD].nvel[1];
	assign result.new_vel_z = pipe_s[ST_ADD].nvel[2];
	assign result.applied   = pipe_s[ST_ADD].ok;
	assign result.index_out = pipe_s[ST_ADD].idx;

	// Every accepted request is followed by its done pulse.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##NUM_STG done)
		else $error("result missing after pipeline latency");

	// The tag travels with its own request.
	a_tag : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.index_out == $past(req.particle_index, NUM_STG)))
		else $error("result tag does not match its request");

	// Without a force the velocity passes through untouched.
	a_pass : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.applied) |->
			(result.new_vel_x == $past(req.vel_x, NUM_STG)) &&
			(result.new_vel_y == $past(req.vel_y, NUM_STG)) &&
			(result.new_vel_z == $past(req.vel_z, NUM_STG)))
		else $error("velocity changed although no force was applied");

endmodule

/* hdl/rffv_cfg.sv */
// ----------------------------------------------------------------------------
// Radial force field configuration registers
// Register bank written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module rffv_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rffv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rffv_pkg::CFG_DAT_W-1:0]   cfg_data,
	output rffv_pkg::cfg_t                   regs
);
	import rffv_pkg::*;

	cfg_t regs_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center_x         <= '0;
			regs_q.center_y         <= '0;
			regs_q.center_z         <= '0;
			regs_q.field_strength   <= STR_W'(65536);
			regs_q.falloff_exponent <= FALL_W'(131072);
			regs_q.max_range        <= RANGE_W'(655360);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: regs_q.center_x         <= cfg_data;
				REG_CENTER_Y: regs_q.center_y         <= cfg_data;
				REG_CENTER_Z: regs_q.center_z         <= cfg_data;
				REG_STRENGTH: regs_q.field_strength   <= cfg_data[STR_W-1:0];
				REG_FALLOFF:  regs_q.falloff_exponent <= cfg_data[FALL_W-1:0];
				REG_RANGE:    regs_q.max_range        <= cfg_data[RANGE_W-1:0];
				default: begin
					// Indexes past the register list are dropped.
				end
			endcase
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Radial force field velocity update testbench
// Streams particle requests through the pipeline under several register
// settings, predicts every updated velocity in fixed point and checks each
// result in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rffv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	radial_force_field_velocity_update_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// One entry of stimulus: either a particle request or a register write.
	typedef struct {
		bit       is_cfg;
		cfg_reg_t reg_sel;
		logic [31:0] value;
		req_t     particle;
	} op_t;

	op_t pending_ops[$];
	rsp_t velocity_expect_q[$];

	// The predictor's own copy of the register bank, updated on accepted writes.
	logic signed [31:0] fc_x = '0, fc_y = '0, fc_z = '0;
	logic signed [STR_W-1:0] f_strength = 23'sd65536;
	logic [FALL_W-1:0] f_falloff = 19'd131072;
	logic [RANGE_W-1:0] f_range = 23'd655360;

	// Center that the stimulus plans around, tracked at the time ops are queued.
	longint plan_cx = 0, plan_cy = 0, plan_cz = 0, plan_range = 655360;

	int errors = 0;
	int n_results = 0;
	int n_applied = 0;
	int idle_left = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// log2 with 16 fraction bits: leading one, then squaring of a Q1.30 mantissa.
	function automatic longint unsigned log2_q16(longint unsigned x);
		int lead = 0;
		longint unsigned mant;
		longint unsigned acc;
		while (lead < 30 && (x >> (lead + 1)) != 0)
			lead++;
		mant = x << (30 - lead);
		acc = lead;
		for (int k = 0; k < LOG_BITS; k++) begin
			mant = (mant * mant) >> 30;
			acc = acc << 1;
			if (mant >= (64'd2 << 30)) begin
				mant = mant >> 1;
				acc = acc | 1;
			end
		end
		return acc;
	endfunction

	// 2^(frac/2^16) in Q1.30 from a chain of successive square roots of two.
	function automatic longint unsigned pow2_frac_q30(longint unsigned frac);
		longint unsigned mant = 64'd1 << 30;
		longint unsigned root2 = int_sqrt(64'd2 << 60);
		for (int k = 0; k < LOG_BITS; k++) begin
			if ((frac >> (LOG_BITS - 1 - k)) & 1)
				mant = (mant * root2) >> 30;
			root2 = int_sqrt(root2 << 30);
		end
		return mant;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic rsp_t predict_velocity(req_t q);
		rsp_t o;
		longint delta[3], vel[3], upd[3];
		longint unsigned mag_d[3];
		longint unsigned lim, radius, m16, smag, prod, quot, mag;
		longint lg, ex, ex_int, ex_frac, sh, strength;
		bit hit = 0;
		delta[0] = longint'(fc_x) - longint'(q.pos_x);
		delta[1] = longint'(fc_y) - longint'(q.pos_y);
		delta[2] = longint'(fc_z) - longint'(q.pos_z);
		vel[0] = longint'(q.vel_x);
		vel[1] = longint'(q.vel_y);
		vel[2] = longint'(q.vel_z);
		lim = longint'(f_range);
		strength = longint'(f_strength);
		for (int i = 0; i < 3; i++) begin
			upd[i] = vel[i];
			mag_d[i] = (delta[i] < 0) ? -delta[i] : delta[i];
		end
		if (mag_d[0] <= lim && mag_d[1] <= lim && mag_d[2] <= lim) begin
			radius = int_sqrt(mag_d[0] * mag_d[0] + mag_d[1] * mag_d[1] + mag_d[2] * mag_d[2]);
			if (radius >= MIN_DIST_RAW && radius <= lim) begin
				hit = 1;
				lg = longint'(log2_q16(radius)) - (longint'(FRAC_BITS) << LOG_BITS);
				ex = -((longint'(f_falloff) * lg) >>> FRAC_BITS);
				ex_int = ex >>> LOG_BITS;
				ex_frac = ex & 64'hFFFF;
				m16 = pow2_frac_q30(ex_frac) >> (30 - MANT_BITS);
				smag = (strength < 0) ? -strength : strength;
				prod = smag * longint'(q.time_step);
				sh = ex_int - FRAC_BITS - MANT_BITS;
				for (int i = 0; i < 3; i++) begin
					quot = ((prod * mag_d[i]) / radius) * m16;
					if (quot == 0)
						mag = 0;
					else if (sh >= 0) begin
						if (sh >= 40 || quot > ((64'd1 << 34) >> sh))
							mag = 64'd1 << 34;
						else
							mag = quot << sh;
					end else begin
						mag = (-sh >= 64) ? 0 : (quot >> (-sh));
					end
					if ((strength < 0) != (delta[i] < 0))
						upd[i] = clamp32(vel[i] - longint'(mag));
					else
						upd[i] = clamp32(vel[i] + longint'(mag));
				end
			end
		end
		o.new_vel_x = upd[0][31:0];
		o.new_vel_y = upd[1][31:0];
		o.new_vel_z = upd[2][31:0];
		o.applied = hit;
		o.index_out = q.particle_index;
		return o;
	endfunction

	// Driver: one request or register write at a time, with random idle gaps.
	always @(posedge clk or negedge arst_n) begin
		bit took_req, took_cfg;
		op_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			idle_left <= 0;
		end else begin
			took_req = start && !busy;
			took_cfg = cfg_valid && cfg_ready;
			if (took_req)
				velocity_expect_q.push_back(predict_velocity(req));
			if (took_cfg) begin
				case (cfg_reg_t'(cfg_index))
					REG_CENTER_X: fc_x = cfg_data;
					REG_CENTER_Y: fc_y = cfg_data;
					REG_CENTER_Z: fc_z = cfg_data;
					REG_STRENGTH: f_strength = cfg_data[STR_W-1:0];
					REG_FALLOFF:  f_falloff = cfg_data[FALL_W-1:0];
					REG_RANGE:    f_range = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end
			if ((start && !took_req) || (cfg_valid && !took_cfg)) begin
				// Request still waiting for its handshake: hold everything.
			end else if (idle_left > 0) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_ops.size() > 0) begin
				nxt = pending_ops[0];
				if (nxt.is_cfg) begin
					start <= 1'b0;
					// Registers change only once the pipeline has drained.
					if (!took_req && velocity_expect_q.size() == 0) begin
						void'(pending_ops.pop_front());
						cfg_valid <= 1'b1;
						cfg_index <= nxt.reg_sel;
						cfg_data <= nxt.value;
					end else begin
						cfg_valid <= 1'b0;
					end
				end else begin
					void'(pending_ops.pop_front());
					cfg_valid <= 1'b0;
					start <= 1'b1;
					req <= nxt.particle;
					idle_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 0;
				end
			end else begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end
		end
	end

	// Monitor: every done pulse is matched against the oldest prediction.
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && done) begin
			if (velocity_expect_q.size() == 0) begin
				$error("result for particle %0d with no request outstanding",
					result.index_out);
				errors++;
			end else begin
				exp_r = velocity_expect_q.pop_front();
				n_results++;
				if (exp_r.applied)
					n_applied++;
				if (result.new_vel_x !== exp_r.new_vel_x) begin
					$error("new_vel_x expected %0d got %0d", exp_r.new_vel_x, result.new_vel_x);
					errors++;
				end
				if (result.new_vel_y !== exp_r.new_vel_y) begin
					$error("new_vel_y expected %0d got %0d", exp_r.new_vel_y, result.new_vel_y);
					errors++;
				end
				if (result.new_vel_z !== exp_r.new_vel_z) begin
					$error("new_vel_z expected %0d got %0d", exp_r.new_vel_z, result.new_vel_z);
					errors++;
				end
				if (result.applied !== exp_r.applied) begin
					$error("applied expected %0d got %0d", exp_r.applied, result.applied);
					errors++;
				end
				if (result.index_out !== exp_r.index_out) begin
					$error("index_out expected %0d got %0d", exp_r.index_out, result.index_out);
					errors++;
				end
			end
		end
	end

	task automatic queue_write(cfg_reg_t sel, logic [31:0] value);
		op_t o;
		o.is_cfg = 1;
		o.reg_sel = sel;
		o.value = value;
		o.particle = '0;
		pending_ops.push_back(o);
		case (sel)
			REG_CENTER_X: plan_cx = longint'(signed'(value));
			REG_CENTER_Y: plan_cy = longint'(signed'(value));
			REG_CENTER_Z: plan_cz = longint'(signed'(value));
			REG_RANGE:    plan_range = longint'(value[RANGE_W-1:0]);
			default: ;
		endcase
	endtask

	// Queue a particle placed at the given offset from the planned center.
	task automatic queue_particle(longint ox, longint oy, longint oz,
			longint vx, longint vy, longint vz, int unsigned dt);
		op_t o;
		o.is_cfg = 0;
		o.reg_sel = REG_CENTER_X;
		o.value = '0;
		o.particle.pos_x = 32'(clamp32(plan_cx - ox));
		o.particle.pos_y = 32'(clamp32(plan_cy - oy));
		o.particle.pos_z = 32'(clamp32(plan_cz - oz));
		o.particle.vel_x = 32'(vx);
		o.particle.vel_y = 32'(vy);
		o.particle.vel_z = 32'(vz);
		o.particle.time_step = DT_W'(dt);
		o.particle.particle_index = IDX_W'($urandom);
		pending_ops.push_back(o);
	endtask

	function automatic longint pick_offset(longint unsigned lim);
		int mode = $urandom_range(0, 9);
		longint span = lim + lim / 4 + 1;
		if (mode == 0)
			return longint'(signed'($urandom)) - plan_cx;
		if (mode == 1)
			return longint'($urandom_range(0, 40)) - 20;
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	function automatic longint pick_velocity();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 64'sd2147483647 - $urandom_range(0, 3)
				: -64'sd2147483648 + $urandom_range(0, 3);
		return longint'(signed'($urandom));
	endfunction

	initial begin
		longint unsigned r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset register values: center at the origin,
		// unit strength, square-law falloff, range 10.0.
		queue_particle(65536, 0, 0, 0, 0, 0, 65536);
		queue_particle(-65536, 32768, -16384, 1000, -1000, 5, 65536);
		queue_particle(0, 0, 0, 123, 456, 789, 65536);       // at the center
		queue_particle(MIN_DIST_RAW, 0, 0, 0, 0, 0, 65536);   // just far enough
		queue_particle(MIN_DIST_RAW - 1, 0, 0, 0, 0, 0, 65536); // too close
		queue_particle(1, 1, 1, 7, 7, 7, 65536);
		queue_particle(655360, 0, 0, 0, 0, 0, 65536);         // exactly at range
		queue_particle(655361, 0, 0, 0, 0, 0, 65536);         // one axis beyond
		queue_particle(600000, 600000, 0, 0, 0, 0, 65536);     // length beyond
		queue_particle(1000, 0, 0, 0, 0, 0, 0);               // zero time step
		queue_particle(20, 10, 5, 64'sd2147483647, -64'sd2147483648, 0, 65536);
		queue_particle(-20, -10, -5, 64'sd2147483647, -64'sd2147483648, 0, 131071);
		queue_particle(64'sd2147483648, 64'sd2147483648, 0, 1, 2, 3, 65536); // wide miss
		queue_write(REG_STRENGTH, 32'h0000_0000);             // zero strength
		queue_particle(3000, 0, 0, 11, 22, 33, 65536);
		queue_write(REG_STRENGTH, -32'sd3276800);             // repelling strength of -50.0
		queue_write(REG_FALLOFF, 32'd0);                      // flat field
		queue_particle(3000, -3000, 100, 0, 0, 0, 65536);
		queue_particle(12, -12, 12, -64'sd2147483648, 64'sd2147483647, 9, 65536);
		queue_write(REG_FALLOFF, 32'd327680);
		queue_write(REG_RANGE, 32'd0);                        // nothing in range
		queue_particle(MIN_DIST_RAW, 0, 0, 5, 5, 5, 65536);
		queue_particle(0, 0, 0, 5, 5, 5, 65536);

		// Random phases, each with a complete register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					queue_write(REG_CENTER_X, 32'h7FFF_FFFF);
					queue_write(REG_CENTER_Y, 32'h8000_0000);
					queue_write(REG_CENTER_Z, 32'h0000_0000);
					queue_write(REG_STRENGTH, 32'sd3276800);
					queue_write(REG_FALLOFF, 32'd32768);
					queue_write(REG_RANGE, 32'd6553600);
				end
				1: begin
					queue_write(REG_CENTER_X, 32'h8000_0000);
					queue_write(REG_CENTER_Y, 32'h7FFF_FFFF);
					queue_write(REG_CENTER_Z, $urandom);
					queue_write(REG_STRENGTH, -32'sd3276800);
					queue_write(REG_FALLOFF, 32'd327680);
					queue_write(REG_RANGE, 32'd6554);
				end
				2: begin
					// Raw field values beyond the documented ranges.
					queue_write(REG_CENTER_X, $urandom);
					queue_write(REG_CENTER_Y, $urandom);
					queue_write(REG_CENTER_Z, $urandom);
					queue_write(REG_STRENGTH, $urandom);
					queue_write(REG_FALLOFF, 32'h0007_FFFF);
					queue_write(REG_RANGE, 32'h007F_FFFF);
				end
				default: begin
					queue_write(REG_CENTER_X, $urandom);
					queue_write(REG_CENTER_Y, $urandom);
					queue_write(REG_CENTER_Z, $urandom);
					queue_write(REG_STRENGTH, $urandom_range(0, 6553600) - 3276800);
					queue_write(REG_FALLOFF, $urandom_range(32768, 327680));
					queue_write(REG_RANGE, $urandom_range(6554, 6553600));
				end
			endcase
			r = plan_range;
			for (int n = 0; n < 195; n++)
				queue_particle(pick_offset(r), pick_offset(r), pick_offset(r),
					pick_velocity(), pick_velocity(), pick_velocity(),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
						: $urandom_range(0, 65536));
		end

		while (pending_ops.size() > 0 || start || cfg_valid || velocity_expect_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Checked %0d velocity updates, %0d with force applied.",
			n_results, n_applied);
		$display("Covered the reset registers, a few directed register changes and eight random phases.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rffv_pkg.sv
hdl/rffv_cfg.sv
hdl/radial_force_field_velocity_update_top.sv
dv/tb.sv
